/* hdl/tvss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvss_pkg: shared types and constants of the three-voice sine synthesiser
// Register codes, voice indexing, memory write control and sine table builder.
// ----------------------------------------------------------------------------
package tvss_pkg;

	localparam int VOICES     = 3;
	localparam int VOICE_W    = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int STEP_W     = 32;
	localparam int GAIN_W     = 16;

	// output queue; depth must stay a power of two (pointers wrap naturally)
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	typedef logic [VOICE_W-1:0]   tvss_voice_t;
	typedef logic [CFG_IDX_W-1:0] tvss_reg_idx_t;

	localparam tvss_voice_t VOICE_FIRST = 2'd0;
	localparam tvss_voice_t VOICE_TWO   = 2'd1;
	localparam tvss_voice_t VOICE_LAST  = 2'd2;

	localparam tvss_reg_idx_t REG_STEP_ONE   = 3'd0;
	localparam tvss_reg_idx_t REG_STEP_TWO   = 3'd1;
	localparam tvss_reg_idx_t REG_STEP_THREE = 3'd2;
	localparam tvss_reg_idx_t REG_GAIN       = 3'd3;
	localparam tvss_reg_idx_t REG_VOICE_MODE = 3'd4;

	localparam logic [GAIN_W-1:0] GAIN_FULL  = 16'd32768;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

	// phase memory write control
	typedef struct packed {
		logic        en;
		tvss_voice_t addr;
	} tvss_wr_t;

	// Quarter-wave entry k: Taylor series through x^13 in Q30, every term
	// truncated, then scaled to the peak amplitude with rounding and clamped.
	function automatic logic [31:0] sine_entry(input int unsigned k,
		input int unsigned tbits, input int unsigned sbits);
		logic [63:0] amp;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		int unsigned n;
		amp  = (64'd1 << (sbits - 1)) - 64'd1;
		x    = (64'(k) * 64'(HALF_PI_Q30)) >> (tbits - 2);
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		for (n = 1; n <= 6; n++) begin
			term = (term * x2) >> 30;
			unique case (n)
				1: term = term / 64'd6;
				2: term = term / 64'd20;
				3: term = term / 64'd42;
				4: term = term / 64'd72;
				5: term = term / 64'd110;
				default: term = term / 64'd156;
			endcase
			if ((n & 1) != 0) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		sum = {32'd0, sum[31:0]};
		v   = (sum * amp + (64'd1 << 29)) >> 30;
		if (v > amp) begin
			v = amp;
		end
		return v[31:0];
	endfunction

endpackage

/* hdl/three_voice_sine_synth_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_voice_sine_synth_core: three-voice DDS sine synthesiser
// Per input transaction: one audio sample from three phase accumulators,
// a shared quarter-wave sine table, Q15 gain and optional three-voice average.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | to core   | in_valid / in_stall   | restart (1 b)
//  out     | from core | out_valid / out_stall | sample (SAMPLE_BITS, signed)
//  cfg     | to core   | cfg_we                | cfg_idx (3 b), cfg_data (32 b)
//
//  Voices: each transaction sweeps the three voices in turn through the single
//  phase memory read port and the single sine table port; the next transaction
//  can be accepted while the last voice of the current sweep issues.
//  Reset: asynchronous, clears control, registers to their defaults and the
//  phase memory valid bits; no clearing pass.
//  Stalls: up to FIFO_DEPTH (4) transactions may be in flight or queued; the
//  input stalls only when all credits are taken or a voice sweep is running.
//
// Pipeline (voices follow one another through each stage):
//  S0 issue voice, read phase memory
//  S1 restart / phase select, phase + step written back, table address
//  S2 table data * gain
//  S3 signed accumulate over the three voices (voice one only in single-voice mode)
//  S4 magnitude * reciprocal of three
//  S5 select, push into the result queue
// ----------------------------------------------------------------------------
module three_voice_sine_synth_core #(
	parameter int PHASE_BITS  = 32,
	parameter int TABLE_BITS  = 10,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  tvss_pkg::tvss_reg_idx_t             cfg_idx,
	input  logic [tvss_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SAMPLE_BITS-1:0]       sample
);
	import tvss_pkg::*;

	localparam int MAG_W  = SAMPLE_BITS - 1;     // table magnitude
	localparam int ACC_W  = SAMPLE_BITS + 2;     // holds +/- 3 * peak
	localparam int ABS_W  = SAMPLE_BITS + 1;     // |sum of three|
	localparam int ADDR_W = TABLE_BITS - 1;      // 0 .. quarter size inclusive
	localparam int OFF_W  = TABLE_BITS - 2;
	// x / 3 == (x * ceil(2^(ABS_W+1) / 3)) >> (ABS_W+1) for any ABS_W-bit x
	localparam logic [ABS_W-1:0] RECIP3 = ABS_W'(((1 << (ABS_W + 1)) + 2) / 3);
	localparam logic [ADDR_W-1:0] QTR   = ADDR_W'(1 << OFF_W);

	// ---------------------------------------------------------------- config
	logic [STEP_W-1:0] step_one_q;
	logic [STEP_W-1:0] step_two_q;
	logic [STEP_W-1:0] step_three_q;
	logic [GAIN_W-1:0] gain_q;
	logic              voice_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_one_q   <= '0;
			step_two_q   <= '0;
			step_three_q <= '0;
			gain_q       <= GAIN_RESET;
			voice_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_STEP_ONE:   step_one_q   <= cfg_data[STEP_W-1:0];
				REG_STEP_TWO:   step_two_q   <= cfg_data[STEP_W-1:0];
				REG_STEP_THREE: step_three_q <= cfg_data[STEP_W-1:0];
				REG_GAIN:       gain_q       <= cfg_data[GAIN_W-1:0];
				REG_VOICE_MODE: voice_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ----------------------------------------------------- issue / credits
	// One credit per queue entry, taken at accept and returned at pop, so
	// the datapath never has to stall.
	logic                  busy_q;
	tvss_voice_t           cnt_q;
	logic                  rst_q;
	logic [FIFO_CNT_W-1:0] outstanding_q;
	logic                  can_take;
	logic                  in_acc;
	logic                  out_pop;

	assign can_take = (!busy_q || cnt_q == VOICE_LAST) &&
		(outstanding_q < FIFO_CNT_W'(FIFO_DEPTH));
	assign in_stall = !can_take;
	assign in_acc   = in_valid && can_take;
	assign out_pop  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			cnt_q         <= VOICE_FIRST;
			rst_q         <= 1'b0;
			outstanding_q <= '0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
				cnt_q  <= VOICE_FIRST;
				rst_q  <= restart;
			end else if (busy_q) begin
				if (cnt_q == VOICE_LAST) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (in_acc && !out_pop) begin
				outstanding_q <= outstanding_q + 1'b1;
			end else if (out_pop && !in_acc) begin
				outstanding_q <= outstanding_q - 1'b1;
			end
		end
	end

	// ------------------------------------------------------- S0 -> S1
	logic        vld_s1;
	tvss_voice_t voice_s1;
	logic        restart_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		voice_s1   <= cnt_q;
		restart_s1 <= rst_q;
	end

	// ---------------------------------------------------------------- S1
	// Each entry is read at S0 and written at the end of S1; the same voice
	// is not read again before its write-back has landed, so no forwarding.
	logic [PHASE_BITS-1:0] phase_rd;
	logic [PHASE_BITS-1:0] phase_cur;
	logic [PHASE_BITS-1:0] step_sel;
	tvss_wr_t              ph_wr;
	logic [TABLE_BITS-1:0] idx;
	logic [1:0]            quad;
	logic [OFF_W-1:0]      off;
	logic [ADDR_W-1:0]     tab_addr;

	tvss_phase_ram #(
		.PHASE_BITS (PHASE_BITS)
	) u_phase_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (busy_q),
		.rd_addr (cnt_q),
		.rd_data (phase_rd),
		.wr      (ph_wr),
		.wr_data (phase_cur + step_sel)
	);

	always_comb begin
		unique case (voice_s1)
			VOICE_FIRST: step_sel = PHASE_BITS'(step_one_q);
			VOICE_TWO:   step_sel = PHASE_BITS'(step_two_q);
			VOICE_LAST:  step_sel = PHASE_BITS'(step_three_q);
			default:     step_sel = '0;
		endcase
	end

	// sample uses the phase before this step's increment
	assign phase_cur  = restart_s1 ? '0 : phase_rd;
	assign ph_wr.en   = vld_s1;
	assign ph_wr.addr = voice_s1;

	assign idx      = phase_cur[PHASE_BITS-1 -: TABLE_BITS];
	assign quad     = idx[TABLE_BITS-1 -: 2];
	assign off      = idx[OFF_W-1:0];
	// odd quadrants run the quarter table backwards
	assign tab_addr = quad[0] ? (QTR - ADDR_W'(off)) : ADDR_W'(off);

	logic [MAG_W-1:0] tab_mag;

	tvss_sine_rom #(
		.TABLE_BITS  (TABLE_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_sine_rom (
		.clk   (clk),
		.rd_en (vld_s1),
		.addr  (tab_addr),
		.data  (tab_mag)
	);

	logic        vld_s2;
	tvss_voice_t voice_s2;
	logic        neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		voice_s2 <= voice_s1;
		neg_s2   <= quad[1];
	end

	// ---------------------------------------------------------------- S2
	// gain above full scale acts as full scale, so the product never grows
	logic [GAIN_W-1:0]       gain_eff;
	logic [MAG_W+GAIN_W-1:0] gprod;

	assign gain_eff = (gain_q > GAIN_FULL) ? GAIN_FULL : gain_q;
	assign gprod    = (MAG_W + GAIN_W)'(tab_mag) * (MAG_W + GAIN_W)'(gain_eff);

	logic             vld_s3;
	tvss_voice_t      voice_s3;
	logic             neg_s3;
	logic [MAG_W-1:0] gmag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		voice_s3 <= voice_s2;
		neg_s3   <= neg_s2;
		gmag_s3  <= gprod[MAG_W+14:15];
	end

	// ---------------------------------------------------------------- S3
	logic signed [ACC_W-1:0] vsig;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_next;

	assign vsig = neg_s3 ? -$signed(ACC_W'(gmag_s3)) : $signed(ACC_W'(gmag_s3));

	always_comb begin
		if (voice_s3 == VOICE_FIRST) begin
			acc_next = vsig;
		end else if (voice_mode_q) begin
			acc_next = acc_q + vsig;
		end else begin
			acc_next = acc_q;
		end
	end

	logic                    vld_s4;
	logic signed [ACC_W-1:0] acc_s4;

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			acc_q <= acc_next;
		end
		acc_s4 <= acc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3 && (voice_s3 == VOICE_LAST);
		end
	end

	// ---------------------------------------------------------------- S4
	logic             neg4;
	logic [ACC_W-1:0] abs4;
	logic [2*ABS_W-1:0] dprod;

	assign neg4  = acc_s4[ACC_W-1];
	assign abs4  = neg4 ? ACC_W'(-acc_s4) : ACC_W'(acc_s4);
	assign dprod = (2 * ABS_W)'(abs4[ABS_W-1:0]) * (2 * ABS_W)'(RECIP3);

	logic                   vld_s5;
	logic                   neg_s5;
	logic [SAMPLE_BITS-1:0] quot_s5;
	logic [SAMPLE_BITS-1:0] raw_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		neg_s5  <= neg4;
		quot_s5 <= dprod[2*ABS_W-1:ABS_W+1];
		raw_s5  <= acc_s4[SAMPLE_BITS-1:0];
	end

	// ---------------------------------------------------------------- S5
	logic [SAMPLE_BITS-1:0] res_s5;

	always_comb begin
		if (voice_mode_q) begin
			res_s5 = neg_s5 ? -quot_s5 : quot_s5;
		end else begin
			res_s5 = raw_s5;
		end
	end

	logic [SAMPLE_BITS-1:0] q_data;

	tvss_out_fifo #(
		.WIDTH (SAMPLE_BITS)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (vld_s5),
		.push_data (res_s5),
		.pop       (out_pop),
		.valid     (out_valid),
		.data      (q_data)
	);

	assign sample = $signed(q_data);

	// ------------------------------------------------------------ checks
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("credit count above queue depth");

	a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && busy_q |-> voice_s1 != cnt_q)
		else $error("phase entry read while its write-back is pending");

	a_out_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> outstanding_q != '0)
		else $error("result offered with no transaction outstanding");

	a_sweep_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q == VOICE_FIRST |-> $past(in_acc))
		else $error("voice sweep started without an accepted transaction");

endmodule

/* hdl/tvss_phase_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvss_phase_ram: phase accumulator store
// One entry per voice, registered read, one write port. Per-entry valid bits
// make an unwritten entry read as zero after reset.
// ----------------------------------------------------------------------------
module tvss_phase_ram #(
	parameter int PHASE_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  tvss_pkg::tvss_voice_t    rd_addr,
	output logic [PHASE_BITS-1:0]    rd_data,
	input  tvss_pkg::tvss_wr_t       wr,
	input  logic [PHASE_BITS-1:0]    wr_data
);
	import tvss_pkg::*;

	logic [PHASE_BITS-1:0] mem [0:VOICES-1];
	logic [VOICES-1:0]     vld_q;
	logic [PHASE_BITS-1:0] data_q;
	logic                  hit_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr_data;
		end
		if (rd_en) begin
			data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = hit_q ? data_q : '0;

endmodule

/* hdl/tvss_sine_rom.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvss_sine_rom: quarter-wave sine table
// Entries 0..2^(TABLE_BITS-2) built at elaboration, registered read port.
// ----------------------------------------------------------------------------
module tvss_sine_rom #(
	parameter int TABLE_BITS  = 10,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   rd_en,
	input  logic [TABLE_BITS-2:0]  addr,
	output logic [SAMPLE_BITS-2:0] data
);
	import tvss_pkg::*;

	localparam int QTR   = 1 << (TABLE_BITS - 2);
	localparam int MAG_W = SAMPLE_BITS - 1;

	logic [MAG_W-1:0] tab [0:QTR];
	logic [MAG_W-1:0] data_q;

	for (genvar k = 0; k <= QTR; k++) begin : g_entry
		localparam logic [31:0] ENTRY = sine_entry(k, TABLE_BITS, SAMPLE_BITS);
		assign tab[k] = ENTRY[MAG_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_q <= tab[addr];
		end
	end

	assign data = data_q;

endmodule

/* hdl/tvss_out_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvss_out_fifo: result queue
// Small register queue between the datapath and the output channel. Never
// pushed when full: the input side holds a credit per queue entry.
// ----------------------------------------------------------------------------
module tvss_out_fifo #(
	parameter int WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] data
);
	import tvss_pkg::*;

	logic [WIDTH-1:0]      mem [0:FIFO_DEPTH-1];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign valid = (cnt_q != '0);
	assign data  = mem[rd_ptr_q];

endmodule

/* test/three_voice_sine_synth_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_voice_sine_synth_core_tb: self-checking bench for the three-voice DDS
// A short directed plan (silence after reset, quarter-turn steps through every
// quadrant, gain limits, both voice modes), then about 2000 random transactions
// under changing register settings. Every sample is compared with a typed
// value or an in-bench oscillator model. Both handshakes idle in random bursts.
// ----------------------------------------------------------------------------
module three_voice_sine_synth_core_tb;
	import tvss_pkg::*;

	localparam int PH_BITS  = 32;
	localparam int TAB_BITS = 10;
	localparam int SMP_BITS = 16;
	localparam int QTR      = 1 << (TAB_BITS - 2);
	localparam int AMP      = (1 << (SMP_BITS - 1)) - 1;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 12;	// covers the pipeline latency, plus margin
	localparam int HOLD_CYCLES   = 80;	// long receiver hold-off
	localparam int STALL_LIMIT   = 2000;	// cycles with no transaction at all
	localparam int PHASES        = 20;
	localparam int PHASE_ITEMS   = 100;

	typedef enum logic [1:0] {ROW_WRITE, ROW_PREDICT, ROW_KNOWN} row_kind_t;

	// one directed step: a register write, or a transaction whose sample is
	// either typed in here or left to the oscillator model
	typedef struct packed {
		row_kind_t             kind;
		tvss_reg_idx_t         idx;
		logic [31:0]           data;
		logic                  new_note;
		logic signed [15:0]    smp;
	} plan_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	tvss_reg_idx_t                cfg_idx = REG_STEP_ONE;
	logic [CFG_DATA_W-1:0]        cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic                         restart = 1'b0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic signed [SMP_BITS-1:0]   sample;

	// oscillator model state and its copy of the registers
	logic [PH_BITS-1:0]  osc_phase [VOICES];
	logic [STEP_W-1:0]   osc_step [VOICES];
	logic [GAIN_W-1:0]   amp_gain;
	logic                avg_mode;
	logic [15:0]         quarter_wave [0:QTR];

	logic signed [SMP_BITS-1:0] expected_samples [$];

	// idling control shared between the sender and the sample sink
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit hold_req = 1'b0;

	int err_count = 0;
	int samples_checked = 0;
	int items_sent = 0;
	int restarts = 0;
	int settings_loaded = 0;

	// Directed plan. With voice one stepping a quarter turn per sample the
	// table is read at its quadrant edges only, so the samples are 0, +peak,
	// 0, -peak. Gain above full scale must act as full scale; gain zero gives
	// silence; in average mode three equal voices give the single-voice value.
	plan_row_t directed_plan [$] = '{
		'{ROW_KNOWN,   REG_STEP_ONE,   32'h0000_0000, 1'b0, 16'sd0},	// after reset
		'{ROW_KNOWN,   REG_STEP_ONE,   32'h0000_0000, 1'b1, 16'sd0},
		'{ROW_WRITE,   REG_STEP_ONE,   32'h4000_0000, 1'b0, 16'sd0},
		'{ROW_WRITE,   REG_GAIN,       32'd32768,     1'b0, 16'sd0},
		'{ROW_KNOWN,   REG_STEP_ONE,   32'h0000_0000, 1'b1, 16'sd0},
		'{ROW_KNOWN,   REG_STEP_ONE,   32'h0000_0000, 1'b0, 16'sd32767},
		'{ROW_KNOWN,   REG_STEP_ONE,   32'h0000_0000, 1'b0, 16'sd0},
		'{ROW_KNOWN,   REG_STEP_ONE,   32'h0000_0000, 1'b0, -16'sd32767},
		'{ROW_KNOWN,   REG_STEP_ONE,   32'h0000_0000, 1'b0, 16'sd0},	// wrapped
		'{ROW_WRITE,   REG_GAIN,       32'h0000_FFFF, 1'b0, 16'sd0},
		'{ROW_KNOWN,   REG_STEP_ONE,   32'h0000_0000, 1'b1, 16'sd0},
		'{ROW_KNOWN,   REG_STEP_ONE,   32'h0000_0000, 1'b0, 16'sd32767},
		'{ROW_WRITE,   REG_GAIN,       32'h0000_0000, 1'b0, 16'sd0},
		'{ROW_KNOWN,   REG_STEP_ONE,   32'h0000_0000, 1'b0, 16'sd0},
		'{ROW_WRITE,   REG_STEP_TWO,   32'h4000_0000, 1'b0, 16'sd0},
		'{ROW_WRITE,   REG_STEP_THREE, 32'h4000_0000, 1'b0, 16'sd0},
		'{ROW_WRITE,   REG_GAIN,       32'd32768,     1'b0, 16'sd0},
		'{ROW_WRITE,   REG_VOICE_MODE, 32'h0000_0001, 1'b0, 16'sd0},
		'{ROW_KNOWN,   REG_STEP_ONE,   32'h0000_0000, 1'b1, 16'sd0},
		'{ROW_KNOWN,   REG_STEP_ONE,   32'h0000_0000, 1'b0, 16'sd32767},
		'{ROW_KNOWN,   REG_STEP_ONE,   32'h0000_0000, 1'b0, 16'sd0},
		'{ROW_KNOWN,   REG_STEP_ONE,   32'h0000_0000, 1'b0, -16'sd32767},
		'{ROW_WRITE,   REG_STEP_TWO,   32'hFFFF_FFFF, 1'b0, 16'sd0},
		'{ROW_WRITE,   REG_STEP_THREE, 32'h1234_5677, 1'b0, 16'sd0},
		'{ROW_PREDICT, REG_STEP_ONE,   32'h0000_0000, 1'b0, 16'sd0},
		'{ROW_PREDICT, REG_STEP_ONE,   32'h0000_0000, 1'b1, 16'sd0},
		'{ROW_PREDICT, REG_STEP_ONE,   32'h0000_0000, 1'b0, 16'sd0},
		// single-voice mode: voices two and three keep turning unheard
		'{ROW_WRITE,   REG_VOICE_MODE, 32'h0000_0000, 1'b0, 16'sd0},
		'{ROW_WRITE,   REG_STEP_ONE,   32'hFFFF_FFFF, 1'b0, 16'sd0},
		'{ROW_WRITE,   REG_GAIN,       32'h0000_0001, 1'b0, 16'sd0},
		'{ROW_PREDICT, REG_STEP_ONE,   32'h0000_0000, 1'b0, 16'sd0},
		'{ROW_PREDICT, REG_STEP_ONE,   32'h0000_0000, 1'b0, 16'sd0},
		'{ROW_WRITE,   REG_GAIN,       32'd32767,     1'b0, 16'sd0},
		'{ROW_PREDICT, REG_STEP_ONE,   32'h0000_0000, 1'b0, 16'sd0},
		'{ROW_PREDICT, REG_STEP_ONE,   32'h0000_0000, 1'b0, 16'sd0}
	};

	three_voice_sine_synth_core #(
		.PHASE_BITS (PH_BITS),
		.TABLE_BITS (TAB_BITS),
		.SAMPLE_BITS(SMP_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.restart  (restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample   (sample)
	);

	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	// Sample of one transaction: optional phase clear, then each voice reads
	// the table at its current phase and only afterwards steps on.
	function automatic logic signed [SMP_BITS-1:0] predict_sample(input logic new_note);
		logic [TAB_BITS-1:0] addr;
		logic [TAB_BITS-3:0] off;
		logic [15:0]         mag;
		logic [63:0]         eff_gain;
		int                  voice_val;
		int                  mix;
		if (new_note) begin
			for (int i = 0; i < VOICES; i++) osc_phase[i] = '0;
		end
		mix = 0;
		for (int i = 0; i < VOICES; i++) begin
			addr = osc_phase[i][PH_BITS-1 -: TAB_BITS];
			off  = addr[TAB_BITS-3:0];
			// odd quadrants run the quarter wave backwards, upper half negates
			mag  = addr[TAB_BITS-2] ? quarter_wave[QTR - int'(off)] : quarter_wave[off];
			eff_gain = (amp_gain > GAIN_FULL) ? 64'(GAIN_FULL) : 64'(amp_gain);
			voice_val = int'((64'(mag) * eff_gain) >> 15);
			if (addr[TAB_BITS-1]) voice_val = -voice_val;
			if (i == 0 || avg_mode) mix += voice_val;
			osc_phase[i] = osc_phase[i] + osc_step[i];
		end
		// integer division truncates toward zero, as the average must
		if (avg_mode) mix = mix / VOICES;
		return mix[SMP_BITS-1:0];
	endfunction

	// Register write; the model takes the value at the same edge as the core.
	task automatic write_reg(input tvss_reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_STEP_ONE:   osc_step[0] = data[STEP_W-1:0];
			REG_STEP_TWO:   osc_step[1] = data[STEP_W-1:0];
			REG_STEP_THREE: osc_step[2] = data[STEP_W-1:0];
			REG_GAIN:       amp_gain    = data[GAIN_W-1:0];
			REG_VOICE_MODE: avg_mode    = data[0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one transaction and hold it until taken; the payload stays put.
	task automatic send_item(input logic new_note, input logic typed,
		input logic signed [SMP_BITS-1:0] typed_smp);
		logic signed [SMP_BITS-1:0] predicted;
		in_valid <= 1'b1;
		restart  <= new_note;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = predict_sample(new_note);
		expected_samples.push_back(typed ? typed_smp : predicted);
		items_sent++;
		if (new_note) restarts++;
	endtask

	// Stop offering, let every outstanding sample arrive, then let the
	// pipeline go quiet before anything else happens.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_samples.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sample sink: checks each accepted sample and drives out_stall, with
	// random stall bursts and, on request, one long hold-off.
	initial begin : sample_sink
		int                         stall_left;
		logic signed [SMP_BITS-1:0] want;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (expected_samples.size() == 0) begin
					$error("sample: no transaction outstanding, got %0d", sample);
					err_count++;
				end else begin
					want = expected_samples.pop_front();
					if (sample !== want) begin
						$error("sample: expected %0d, actual %0d", want, sample);
						err_count++;
					end
					samples_checked++;
				end
			end
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
				out_stall  <= 1'b1;
				stall_left = $urandom_range(1, 18) - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: too long without any transaction on any channel.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("three_voice_sine_synth_core_tb: done, errors");
		$finish;
	end

	initial begin : stimulus
		logic [63:0]          x;
		logic [63:0]          x2;
		logic [63:0]          term;
		logic [63:0]          series;
		logic [63:0]          scaled;
		logic [STEP_W-1:0]    step_val;
		logic [GAIN_W-1:0]    gain_val;
		logic [CFG_DATA_W-1:0] wdata;
		plan_row_t            row;

		// quarter sine table: Taylor series to x^13 in Q30, every term
		// truncated, then rounded to the peak amplitude and clamped
		for (int k = 0; k <= QTR; k++) begin
			x      = (64'(k) * 64'(HALF_PI_Q30)) >> (TAB_BITS - 2);
			x2     = (x * x) >> 30;
			term   = x;
			series = x;
			for (int n = 1; n <= 6; n++) begin
				term = (term * x2) >> 30;
				term = term / 64'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) series = (series >= term) ? series - term : 64'd0;
				else series = series + term;
			end
			scaled = (64'(series[31:0]) * 64'(AMP) + (64'd1 << 29)) >> 30;
			quarter_wave[k] = (scaled > 64'(AMP)) ? 16'(AMP) : scaled[15:0];
		end

		for (int i = 0; i < VOICES; i++) begin
			osc_phase[i] = '0;
			osc_step[i]  = '0;
		end
		amp_gain = GAIN_RESET;
		avg_mode = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// ---------------- directed plan ----------------
		foreach (directed_plan[r]) begin
			row = directed_plan[r];
			if (row.kind == ROW_WRITE) begin
				drain_results();
				write_reg(row.idx, row.data);
			end else begin
				send_item(row.new_note, row.kind == ROW_KNOWN, row.smp);
			end
		end

		// ---------------- random phases ----------------
		for (int ph = 0; ph < PHASES; ph++) begin
			// idling pattern: some phases run one side flat out, the tail of
			// the run has no idling at all
			tx_gaps = !(ph == 5 || ph % 4 == 2 || ph >= PHASES - 3);
			rx_gaps = !(ph % 4 == 3 || ph >= PHASES - 3);

			drain_results();
			for (int v = 0; v < VOICES; v++) begin
				case ($urandom_range(0, 5))
					0: step_val = '0;
					1: step_val = '1;
					2: step_val = 32'h4000_0000 >> $urandom_range(0, 12);
					3: step_val = 32'($urandom_range(1, 8000)) * 32'd97391;	// ~1 Hz units
					default: step_val = $urandom;
				endcase
				write_reg(tvss_reg_idx_t'(int'(REG_STEP_ONE) + v), step_val);
			end
			case ($urandom_range(0, 5))
				0: gain_val = '0;
				1: gain_val = GAIN_FULL;
				2: gain_val = '1;
				3: gain_val = 16'($urandom_range(int'(GAIN_FULL) + 1, 65535));
				default: gain_val = 16'($urandom_range(0, int'(GAIN_FULL)));
			endcase
			// upper data bits are don't-care for the narrow registers
			wdata = {($urandom_range(0, 1) ? 16'($urandom) : 16'd0), gain_val};
			write_reg(REG_GAIN, wdata);
			wdata = {($urandom_range(0, 1) ? 31'($urandom) : 31'd0), 1'($urandom_range(0, 1))};
			write_reg(REG_VOICE_MODE, wdata);
			// an unmapped index must leave every register alone
			if ($urandom_range(0, 3) == 0) begin
				write_reg(tvss_reg_idx_t'($urandom_range(int'(REG_VOICE_MODE) + 1,
					(1 << CFG_IDX_W) - 1)), $urandom);
			end
			settings_loaded++;

			for (int it = 0; it < PHASE_ITEMS; it++) begin
				// receiver holds off while the sender keeps pushing: the
				// credits run out and the input has to stall
				if (ph == 5 && it == 10) hold_req = 1'b1;
				// sender waits for the core to empty completely mid-phase
				if (ph == 9 && it == PHASE_ITEMS / 2) drain_results();
				if (tx_gaps && $urandom_range(0, 5) == 0) begin
					in_valid <= 1'b0;
					restart  <= 1'($urandom_range(0, 1));
					repeat ($urandom_range(1, 18)) @(posedge clk);
				end
				send_item($urandom_range(0, 11) == 0, 1'b0, '0);
			end
		end

		drain_results();

		$display("three_voice_sine_synth_core_tb: summary: %0d transactions in, %0d samples checked, %0d note restarts",
			items_sent, samples_checked, restarts);
		$display("three_voice_sine_synth_core_tb: summary: %0d random register settings after the directed plan",
			settings_loaded);
		if (err_count == 0) begin
			$display("three_voice_sine_synth_core_tb: done, clean");
		end else begin
			$display("three_voice_sine_synth_core_tb: done, errors");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/tvss_pkg.sv
hdl/tvss_phase_ram.sv
hdl/tvss_sine_rom.sv
hdl/tvss_out_fifo.sv
hdl/three_voice_sine_synth_core.sv
test/three_voice_sine_synth_core_tb.sv
